// ===== sv/rog_pkg.sv =====
package rog_pkg;

   // grid geometry and count width
   localparam int GRID_WIDTH  = 128;
   localparam int GRID_HEIGHT = 128;
   localparam int COUNT_BITS  = 8;

   // transaction field widths
   localparam int FUNC_BITS = 3;
   localparam int POS_BITS  = 9;

   // memory layout: row-major with each row padded to a power of two
   localparam int X_BITS    = $clog2(GRID_WIDTH);
   localparam int Y_BITS    = $clog2(GRID_HEIGHT);
   localparam int ADDR_BITS = X_BITS + Y_BITS;
   localparam int DEPTH     = 1 << ADDR_BITS;

   // scan index must also hold the grid size itself
   localparam int SCAN_BITS = ((X_BITS > Y_BITS) ? X_BITS : Y_BITS) + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_POPULATE   = 3'd0,
      FUNC_DEPOPULATE = 3'd1,
      FUNC_QUERY      = 3'd2,
      FUNC_FREE_X     = 3'd3,
      FUNC_FREE_Y     = 3'd4,
      FUNC_CLEAR      = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      SEL_RECT,
      SEL_LO,
      SEL_HI,
      SEL_WIPE
   } addr_sel_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DISPATCH,
      ST_RECT_RD,
      ST_RECT_WR,
      ST_QUERY_RD,
      ST_LO_TEST,
      ST_LO_CHK,
      ST_HI_TEST,
      ST_HI_CHK,
      ST_WIPE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic         load;
      logic         mem_rd;
      logic         mem_wr;
      addr_sel_type addr_sel;
      logic         rect_init;
      logic         rect_step;
      logic         scan_init;
      logic         lo_dec;
      logic         hi_inc;
      logic         wipe_step;
      logic         out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      logic                 rect_ok;
      logic                 start_ok;
      logic                 rect_last;
      logic                 lo_zero;
      logic                 hi_end;
      logic                 cell_zero;
      logic                 wipe_last;
      logic                 out_free;
   } ctl_status_type;

endpackage

// ===== sv/rog_if.sv =====
interface rog_req_if import rog_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [FUNC_BITS-1:0]       func;
   logic signed [POS_BITS-1:0] x0;
   logic signed [POS_BITS-1:0] y0;
   logic signed [POS_BITS-1:0] x1;
   logic signed [POS_BITS-1:0] y1;

   modport source (output valid, func, x0, y0, x1, y1, input ready);
   modport sink   (input valid, func, x0, y0, x1, y1, output ready);
endinterface

interface rog_rsp_if import rog_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       occupied;
   logic signed [POS_BITS-1:0] free_pos;

   modport source (output valid, occupied, free_pos, input ready);
   modport sink   (input valid, occupied, free_pos, output ready);
endinterface

// ===== sv/rog_ctrl.sv =====
module rog_ctrl import rog_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // hold state; start with the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (status.wipe_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (status.func)
               FUNC_POPULATE, FUNC_DEPOPULATE: begin
                  state_in = status.rect_ok ? ST_RECT_RD : ST_DONE;
               end
               FUNC_QUERY:              state_in = ST_QUERY_RD;
               FUNC_FREE_X, FUNC_FREE_Y: begin
                  state_in = status.start_ok ? ST_LO_TEST : ST_DONE;
               end
               FUNC_CLEAR:              state_in = ST_WIPE;
               default:                 state_in = ST_DONE;
            endcase
         end
         ST_RECT_RD:  state_in = ST_RECT_WR;
         ST_RECT_WR: begin
            state_in = status.rect_last ? ST_DONE : ST_RECT_RD;
         end
         ST_QUERY_RD: state_in = ST_DONE;
         ST_LO_TEST: begin
            state_in = status.lo_zero ? ST_HI_TEST : ST_LO_CHK;
         end
         ST_LO_CHK: begin
            state_in = status.cell_zero ? ST_HI_TEST : ST_LO_TEST;
         end
         ST_HI_TEST: begin
            state_in = status.hi_end ? ST_DONE : ST_HI_CHK;
         end
         ST_HI_CHK: begin
            state_in = status.cell_zero ? ST_DONE : ST_HI_TEST;
         end
         ST_WIPE: begin
            if (status.wipe_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.addr_sel = SEL_RECT;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.mem_wr    = 1'b1;
            cmd.addr_sel  = SEL_WIPE;
            cmd.wipe_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DISPATCH: begin
            cmd.rect_init = 1'b1;
            cmd.scan_init = 1'b1;
         end
         ST_RECT_RD, ST_QUERY_RD: begin
            cmd.mem_rd = 1'b1;
         end
         ST_RECT_WR: begin
            cmd.mem_wr    = 1'b1;
            cmd.rect_step = !status.rect_last;
         end
         ST_LO_TEST: begin
            cmd.mem_rd   = !status.lo_zero;
            cmd.addr_sel = SEL_LO;
         end
         ST_LO_CHK: begin
            cmd.lo_dec = !status.cell_zero;
         end
         ST_HI_TEST: begin
            cmd.mem_rd   = !status.hi_end;
            cmd.addr_sel = SEL_HI;
         end
         ST_HI_CHK: begin
            cmd.hi_inc = !status.cell_zero;
         end
         ST_WIPE: begin
            cmd.mem_wr    = 1'b1;
            cmd.addr_sel  = SEL_WIPE;
            cmd.wipe_step = 1'b1;
         end
         ST_DONE: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // a transaction is taken only when the datapath is told to capture it
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> cmd.load)
      else $error("accepted transaction not captured");

   // a sweep always runs to its end before anything else happens
   a_wipe_continues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WIPE && !status.wipe_last) |=> state_ff == ST_WIPE)
      else $error("clear sweep cut short");

   // a result is loaded only into a free output register
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result overwrote a pending result");

endmodule

// ===== sv/rog_datapath.sv =====
module rog_datapath import rog_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  ctl_cmd_type                cmd,
   output ctl_status_type             status,
   input  logic [FUNC_BITS-1:0]       req_func,
   input  logic signed [POS_BITS-1:0] req_x0,
   input  logic signed [POS_BITS-1:0] req_y0,
   input  logic signed [POS_BITS-1:0] req_x1,
   input  logic signed [POS_BITS-1:0] req_y1,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic                       rsp_occupied,
   output logic signed [POS_BITS-1:0] rsp_free_pos
);

   function automatic logic col_ok(logic signed [POS_BITS-1:0] v);
      return !v[POS_BITS-1] && (32'($unsigned(v)) < GRID_WIDTH);
   endfunction

   function automatic logic row_ok(logic signed [POS_BITS-1:0] v);
      return !v[POS_BITS-1] && (32'($unsigned(v)) < GRID_HEIGHT);
   endfunction

   logic [FUNC_BITS-1:0]       func_ff;
   logic signed [POS_BITS-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic [X_BITS-1:0]          col_ff, col_in;
   logic [Y_BITS-1:0]          row_ff, row_in;
   logic [SCAN_BITS-1:0]       lo_ff, lo_in, hi_ff, hi_in;
   logic [ADDR_BITS-1:0]       wipe_ff, wipe_in;
   logic [COUNT_BITS-1:0]      cell_count_ff [DEPTH];
   logic [COUNT_BITS-1:0]      rdata_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       occupied_ff, occupied_in;
   logic signed [POS_BITS-1:0] free_pos_ff, free_pos_in;

   logic [X_BITS-1:0]          x0_col, x1_col, addr_col;
   logic [Y_BITS-1:0]          y0_row, y1_row, addr_row;
   logic [ADDR_BITS-1:0]       addr;
   logic [COUNT_BITS-1:0]      wdata;
   logic                       along_x, start_ok;
   logic [SCAN_BITS-1:0]       scan_start, scan_limit;
   logic signed [SCAN_BITS+1:0] lo_plus, hi_minus;

   assign x0_col = X_BITS'($unsigned(x0_ff));
   assign x1_col = X_BITS'($unsigned(x1_ff));
   assign y0_row = Y_BITS'($unsigned(y0_ff));
   assign y1_row = Y_BITS'($unsigned(y1_ff));

   assign along_x    = (func_ff == FUNC_FREE_X);
   assign start_ok   = col_ok(x0_ff) && row_ok(y0_ff);
   assign scan_start = along_x ? SCAN_BITS'($unsigned(x0_ff)) : SCAN_BITS'($unsigned(y0_ff));
   assign scan_limit = along_x ? SCAN_BITS'(GRID_WIDTH) : SCAN_BITS'(GRID_HEIGHT);

   // capture the command transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         x0_ff   <= req_x0;
         y0_ff   <= req_y0;
         x1_ff   <= req_x1;
         y1_ff   <= req_y1;
      end
   end

   // advance the rectangle cursor row by row
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.rect_init) begin
         col_in = x0_col;
         row_in = y0_row;
      end else if (cmd.rect_step) begin
         if (col_ff == x1_col) begin
            col_in = x0_col;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // advance the two scan stops
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.scan_init) begin
         lo_in = scan_start;
         hi_in = scan_start;
      end else begin
         if (cmd.lo_dec) lo_in = lo_ff - 1'b1;
         if (cmd.hi_inc) hi_in = hi_ff + 1'b1;
      end
   end

   assign wipe_in = cmd.wipe_step ? wipe_ff + 1'b1 : wipe_ff;

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      row_ff <= row_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
   end

   // sweep counter wraps to zero at the end of each pass
   always_ff @(posedge clock) begin
      if (reset) begin
         wipe_ff <= '0;
      end else begin
         wipe_ff <= wipe_in;
      end
   end

   // select the cell address
   always_comb begin
      addr_row = row_ff;
      addr_col = col_ff;
      case (cmd.addr_sel)
         SEL_RECT: begin
            addr_row = row_ff;
            addr_col = col_ff;
         end
         SEL_LO: begin
            addr_row = along_x ? y0_row : lo_ff[Y_BITS-1:0];
            addr_col = along_x ? lo_ff[X_BITS-1:0] : x0_col;
         end
         SEL_HI: begin
            addr_row = along_x ? y0_row : hi_ff[Y_BITS-1:0];
            addr_col = along_x ? hi_ff[X_BITS-1:0] : x0_col;
         end
         SEL_WIPE: begin
            addr_row = wipe_ff[ADDR_BITS-1:X_BITS];
            addr_col = wipe_ff[X_BITS-1:0];
         end
         default: begin
            addr_row = row_ff;
            addr_col = col_ff;
         end
      endcase
   end

   assign addr = {addr_row, addr_col};

   // saturating count update, or zero for the sweep
   always_comb begin
      if (cmd.addr_sel == SEL_WIPE) begin
         wdata = '0;
      end else if (func_ff == FUNC_POPULATE) begin
         wdata = (rdata_ff == COUNT_MAX) ? rdata_ff : rdata_ff + 1'b1;
      end else begin
         wdata = (rdata_ff == '0) ? rdata_ff : rdata_ff - 1'b1;
      end
   end

   // count memory, one port
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) cell_count_ff[addr] <= wdata;
      if (cmd.mem_rd) rdata_ff <= cell_count_ff[addr];
   end

   // form the result
   assign lo_plus  = $signed({2'b00, lo_ff}) + (SCAN_BITS+2)'(2);
   assign hi_minus = $signed({2'b00, hi_ff}) - (SCAN_BITS+2)'(2);

   always_comb begin
      occupied_in = 1'b0;
      free_pos_in = '0;
      case (func_ff)
         FUNC_QUERY: begin
            occupied_in = start_ok && (rdata_ff != '0);
         end
         FUNC_FREE_X, FUNC_FREE_Y: begin
            if (!start_ok) begin
               free_pos_in = '1;
            end else if ((scan_start - lo_ff) < (hi_ff - scan_start)) begin
               free_pos_in = POS_BITS'(lo_plus);
            end else begin
               free_pos_in = POS_BITS'(hi_minus);
            end
         end
         default: begin
            occupied_in = 1'b0;
            free_pos_in = '0;
         end
      endcase
   end

   // output register; drop valid once the transaction is taken
   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         occupied_ff <= occupied_in;
         free_pos_ff <= free_pos_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_occupied = occupied_ff;
   assign rsp_free_pos = free_pos_ff;

   // status to the controller
   always_comb begin
      status.func      = func_ff;
      status.rect_ok   = start_ok && col_ok(x1_ff) && row_ok(y1_ff)
                         && (x0_ff <= x1_ff) && (y0_ff <= y1_ff);
      status.start_ok  = start_ok;
      status.rect_last = (col_ff == x1_col) && (row_ff == y1_row);
      status.lo_zero   = (lo_ff == '0);
      status.hi_end    = (hi_ff == scan_limit);
      status.cell_zero = (rdata_ff == '0);
      status.wipe_last = (wipe_ff == ADDR_BITS'(DEPTH - 1));
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // rectangle writes happen only for a rectangle inside the grid
   a_rect_write_ok: assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_wr && cmd.addr_sel == SEL_RECT) |-> status.rect_ok)
      else $error("rectangle write outside the grid");

   // the right scan never reads at or beyond the grid edge
   a_hi_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_rd && cmd.addr_sel == SEL_HI) |-> (hi_ff < scan_limit))
      else $error("right scan read past grid edge");

   // scan stops stay on their own sides of the start
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.lo_dec || cmd.hi_inc) |-> (lo_ff <= scan_start && hi_ff >= scan_start))
      else $error("scan stop crossed start");

   // a loaded result is presented next cycle
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

// ===== sv/rect_occupancy_grid.sv =====
// Occupancy grid of GRID_WIDTH x GRID_HEIGHT saturating counts held in one
// single-port memory; every command transaction yields exactly one response.
// Commands run one at a time through the memory port: populate/depopulate
// read and then write each cell of the rectangle, row by row; query reads
// one cell; a free-x/free-y search reads cells outward from the start, first
// on the low side and then on the high side, each until a zero cell or the
// grid edge; clear walks the whole padded memory of 2^(clog2(W)+clog2(H))
// cells, 16384 at 128x128. A command that is rejected or carries an unused
// code goes straight to its response. After reset the same clearing pass
// runs before the first command is accepted. A finished response sits in an
// output register, so the next command can be accepted while it waits; a
// command finishes only once that register is free again.
module rect_occupancy_grid import rog_pkg::*; (
   input logic        clock,
   input logic        reset,
   rog_req_if.sink    req_ch,
   rog_rsp_if.source  rsp_ch
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   rog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rog_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_func     (req_ch.func),
      .req_x0       (req_ch.x0),
      .req_y0       (req_ch.y0),
      .req_x1       (req_ch.x1),
      .req_y1       (req_ch.y1),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_occupied (rsp_ch.occupied),
      .rsp_free_pos (rsp_ch.free_pos)
   );

endmodule

// ===== tb/tb.sv =====
module tb;
   import rog_pkg::*;

   // func codes that the block leaves unused
   localparam logic [FUNC_BITS-1:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [FUNC_BITS-1:0] FUNC_SPARE_7 = 3'd7;

   localparam int  IDLE_PCT     = 26;
   localparam int  MAX_REPORTS  = 10;
   localparam int  RANDOM_ITEMS = 160;
   localparam int  HOLD_CYCLES  = 3000;
   localparam int  CYCLE_LIMIT  = 3000000;
   localparam int  SETTLE       = 40;
   localparam bit  PREDICT      = 1'b0;
   localparam bit  TYPED        = 1'b1;

   typedef struct packed {
      logic [FUNC_BITS-1:0]       func;
      logic signed [POS_BITS-1:0] x0;
      logic signed [POS_BITS-1:0] y0;
      logic signed [POS_BITS-1:0] x1;
      logic signed [POS_BITS-1:0] y1;
   } grid_cmd_type;

   typedef struct packed {
      logic                       occupied;
      logic signed [POS_BITS-1:0] free_pos;
   } grid_rsp_type;

   typedef struct packed {
      grid_cmd_type cmd;
      grid_rsp_type rsp;
   } answer_type;

   typedef struct packed {
      grid_cmd_type cmd;
      logic         typed;
      grid_rsp_type rsp;
   } table_row_type;

   logic clock;
   logic reset;

   rog_req_if req_ch();
   rog_rsp_if rsp_ch();

   rect_occupancy_grid DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow copy of the grid
   logic [COUNT_BITS-1:0] grid_cnt [GRID_HEIGHT][GRID_WIDTH];

   answer_type    answers[$];
   table_row_type directed_rows[$];

   int  cycle_cnt    = 0;
   int  rsp_count    = 0;
   int  mismatches   = 0;
   bit  sender_quiet = 1'b0;
   bit  hold_armed   = 1'b0;
   bit  hold_done    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
   end

   // stop a hung run
   initial begin
      while (cycle_cnt < CYCLE_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   function automatic bit in_grid(int x, int y);
      return x >= 0 && x < GRID_WIDTH && y >= 0 && y < GRID_HEIGHT;
   endfunction

   function automatic void grid_wipe();
      foreach (grid_cnt[j, i]) grid_cnt[j][i] = '0;
   endfunction

   function automatic logic [COUNT_BITS-1:0] cell_along(int x, int y, int k, bit along_x);
      return along_x ? grid_cnt[y][k] : grid_cnt[k][x];
   endfunction

   // scan both ways from (x,y) and return the spot two cells in from the nearer stop
   function automatic int closest_free(int x, int y, bit along_x);
      int start, lim, lo, hi, dlo, dhi;
      if (!in_grid(x, y)) return -1;
      start = along_x ? x : y;
      lim   = along_x ? GRID_WIDTH : GRID_HEIGHT;
      dlo   = 0;
      dhi   = 0;
      lo    = start;
      while (lo > 0 && cell_along(x, y, lo, along_x) != '0) begin
         dlo++;
         lo--;
      end
      hi = start;
      while (hi < lim && cell_along(x, y, hi, along_x) != '0) begin
         dhi++;
         hi++;
      end
      return (dlo < dhi) ? lo + 2 : hi - 2;
   endfunction

   // apply one command to the shadow grid and return its response
   function automatic grid_rsp_type grid_apply(grid_cmd_type c);
      grid_rsp_type r;
      int x0, y0, x1, y1;
      r  = '0;
      x0 = c.x0;
      y0 = c.y0;
      x1 = c.x1;
      y1 = c.y1;
      case (c.func)
         FUNC_POPULATE, FUNC_DEPOPULATE: begin
            if (in_grid(x0, y0) && in_grid(x1, y1)) begin
               for (int j = y0; j <= y1; j++) begin
                  for (int i = x0; i <= x1; i++) begin
                     if (c.func == FUNC_POPULATE) begin
                        if (grid_cnt[j][i] != COUNT_MAX) grid_cnt[j][i]++;
                     end else begin
                        if (grid_cnt[j][i] != '0) grid_cnt[j][i]--;
                     end
                  end
               end
            end
         end
         FUNC_QUERY:  r.occupied = in_grid(x0, y0) && grid_cnt[y0][x0] != '0;
         FUNC_FREE_X: r.free_pos = POS_BITS'(closest_free(x0, y0, 1'b1));
         FUNC_FREE_Y: r.free_pos = POS_BITS'(closest_free(x0, y0, 1'b0));
         FUNC_CLEAR:  grid_wipe();
         default: ;
      endcase
      return r;
   endfunction

   function automatic int jitter(int c, int s, int lim);
      int v;
      v = c + int'($urandom_range(2 * s)) - s;
      if (v < -1) v = -1;
      if (v > lim) v = lim;
      return v;
   endfunction

   function automatic int any_coord(int lim);
      return int'($urandom_range(lim + 1)) - 1;
   endfunction

   // mostly rectangles and probes around a hot spot, with some noise
   function automatic grid_cmd_type random_cmd(int cx, int cy);
      grid_cmd_type c;
      int sel, w, h, x0, y0, x1, y1, t;
      bit wide;
      sel  = $urandom_range(199);
      x0   = jitter(cx, 12, GRID_WIDTH);
      y0   = jitter(cy, 12, GRID_HEIGHT);
      wide = ($urandom_range(19) == 0);
      w    = wide ? $urandom_range(31) : $urandom_range(7);
      h    = wide ? $urandom_range(31) : $urandom_range(7);
      x1   = (x0 + w > GRID_WIDTH) ? GRID_WIDTH : x0 + w;
      y1   = (y0 + h > GRID_HEIGHT) ? GRID_HEIGHT : y0 + h;
      if ($urandom_range(11) == 0) begin
         t  = x0;
         x0 = x1;
         x1 = t;
      end
      if ($urandom_range(11) == 0) begin
         t  = y0;
         y0 = y1;
         y1 = t;
      end
      if (sel < 3) begin
         c.func = FUNC_CLEAR;
      end else if (sel < 5) begin
         c.func = (sel == 3) ? FUNC_SPARE_6 : FUNC_SPARE_7;
      end else if (sel < 20) begin
         c.func = FUNC_BITS'($urandom_range(4));
         x0 = any_coord(GRID_WIDTH);
         y0 = any_coord(GRID_HEIGHT);
         x1 = any_coord(GRID_WIDTH);
         y1 = any_coord(GRID_HEIGHT);
      end else if (sel < 80) begin
         c.func = FUNC_POPULATE;
         // build long runs for the free searches
         if ($urandom_range(9) == 0) begin
            if ($urandom_range(1) == 1) begin
               x0 = 0;
               x1 = GRID_WIDTH - 1;
               y1 = y0;
            end else begin
               y0 = 0;
               y1 = GRID_HEIGHT - 1;
               x1 = x0;
            end
         end
      end else if (sel < 110) begin
         c.func = FUNC_DEPOPULATE;
      end else if (sel < 140) begin
         c.func = FUNC_QUERY;
      end else if (sel < 170) begin
         c.func = FUNC_FREE_X;
      end else begin
         c.func = FUNC_FREE_Y;
      end
      c.x0 = POS_BITS'(x0);
      c.y0 = POS_BITS'(y0);
      c.x1 = POS_BITS'(x1);
      c.y1 = POS_BITS'(y1);
      return c;
   endfunction

   function automatic void add_row(bit typed, logic [FUNC_BITS-1:0] f, int x0, int y0,
                                   int x1, int y1, bit occ, int pos);
      table_row_type row;
      row.cmd.func     = f;
      row.cmd.x0       = POS_BITS'(x0);
      row.cmd.y0       = POS_BITS'(y0);
      row.cmd.x1       = POS_BITS'(x1);
      row.cmd.y1       = POS_BITS'(y1);
      row.typed        = typed;
      row.rsp.occupied = occ;
      row.rsp.free_pos = POS_BITS'(pos);
      directed_rows.push_back(row);
   endfunction

   // offer one command, hold it until accepted, then record its answer
   task automatic send_cmd(grid_cmd_type c, bit typed, grid_rsp_type want);
      grid_rsp_type r;
      if (!sender_quiet) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= c.func;
      req_ch.x0    <= c.x0;
      req_ch.y0    <= c.y0;
      req_ch.x1    <= c.x1;
      req_ch.y1    <= c.y1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      r = grid_apply(c);
      answers.push_back('{cmd: c, rsp: (typed ? want : r)});
   endtask

   // response side: random stalls, one long hold-off, one stretch always ready
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (rsp_count >= 320 && rsp_count < 400) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // compare each response transaction with the oldest answer
   always @(posedge clock) begin : rsp_monitor
      answer_type a;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         rsp_count = rsp_count + 1;
         if (answers.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response %0d unexpected: occupied=%0b free_pos=%0d",
                        rsp_count, rsp_ch.occupied, rsp_ch.free_pos);
         end else begin
            a = answers.pop_front();
            if (rsp_ch.occupied !== a.rsp.occupied || rsp_ch.free_pos !== a.rsp.free_pos) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"mismatch on response %0d (func=%0d x0=%0d y0=%0d x1=%0d y1=%0d): ",
                            "expected occupied=%0b free_pos=%0d, got occupied=%0b free_pos=%0d"},
                           rsp_count, a.cmd.func, a.cmd.x0, a.cmd.y0, a.cmd.x1, a.cmd.y1,
                           a.rsp.occupied, a.rsp.free_pos, rsp_ch.occupied, rsp_ch.free_pos);
            end
         end
      end
   end

   initial begin
      int           cx, cy, sx, sy;
      grid_cmd_type c;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.func  <= FUNC_QUERY;
      req_ch.x0    <= '0;
      req_ch.y0    <= '0;
      req_ch.x1    <= '0;
      req_ch.y1    <= '0;
      grid_wipe();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty grid, out-of-grid positions, searches from empty cells
      add_row(TYPED,   FUNC_QUERY,       0,   0,   0,   0, 1'b0,   0);
      add_row(TYPED,   FUNC_QUERY,     127, 127, 127, 127, 1'b0,   0);
      add_row(TYPED,   FUNC_QUERY,      -1,  -1,  -1,  -1, 1'b0,   0);
      add_row(TYPED,   FUNC_FREE_X,      0,   0,   0,   0, 1'b0,  -2);
      add_row(TYPED,   FUNC_FREE_Y,    127, 127,   0,   0, 1'b0, 125);
      add_row(TYPED,   FUNC_FREE_X,     -1,   5,   0,   0, 1'b0,  -1);
      add_row(TYPED,   FUNC_FREE_Y,      5, 128,   0,   0, 1'b0,  -1);
      // whole grid filled, searches run to both borders
      add_row(TYPED,   FUNC_POPULATE,    0,   0, 127, 127, 1'b0,   0);
      add_row(TYPED,   FUNC_QUERY,     127,   0,   0,   0, 1'b1,   0);
      add_row(PREDICT, FUNC_FREE_X,     64,  10,   0,   0, 1'b0,   0);
      add_row(PREDICT, FUNC_FREE_Y,      0,   0,   0,   0, 1'b0,   0);
      add_row(PREDICT, FUNC_FREE_X,    127, 127,   0,   0, 1'b0,   0);
      add_row(PREDICT, FUNC_DEPOPULATE,  0,   0, 127, 127, 1'b0,   0);
      // depopulate at zero, empty and rejected rectangles
      add_row(PREDICT, FUNC_DEPOPULATE, 10,  10,  12,  12, 1'b0,   0);
      add_row(PREDICT, FUNC_POPULATE,   20,   5,  10,   6, 1'b0,   0);
      add_row(PREDICT, FUNC_POPULATE,    5,  20,   6,  10, 1'b0,   0);
      add_row(PREDICT, FUNC_POPULATE,   -1,   0,   5,   5, 1'b0,   0);
      add_row(PREDICT, FUNC_POPULATE,    0,   0, 128,   3, 1'b0,   0);
      add_row(PREDICT, FUNC_POPULATE,    3,   3,   4,  -1, 1'b0,   0);
      // a cross of occupied cells, probed from its center
      add_row(PREDICT, FUNC_POPULATE,   40,  40,  47,  40, 1'b0,   0);
      add_row(PREDICT, FUNC_POPULATE,   43,  36,  43,  45, 1'b0,   0);
      add_row(PREDICT, FUNC_FREE_X,     44,  40,   0,   0, 1'b0,   0);
      add_row(PREDICT, FUNC_FREE_Y,     43,  40,   0,   0, 1'b0,   0);
      add_row(PREDICT, FUNC_FREE_X,     43,  40,   0,   0, 1'b0,   0);
      // unused codes, then clear
      add_row(TYPED,   FUNC_SPARE_6,    40,  40,  47,  47, 1'b0,   0);
      add_row(TYPED,   FUNC_SPARE_7,   128, 128,  -1,  -1, 1'b0,   0);
      add_row(TYPED,   FUNC_CLEAR,       0,   0,   0,   0, 1'b0,   0);
      add_row(TYPED,   FUNC_QUERY,      43,  40,   0,   0, 1'b0,   0);

      foreach (directed_rows[k])
         send_cmd(directed_rows[k].cmd, directed_rows[k].typed, directed_rows[k].rsp);

      // drive a pair of cells past saturation, then step one down
      sx     = $urandom_range(GRID_WIDTH - 2);
      sy     = $urandom_range(GRID_HEIGHT - 1);
      c.func = FUNC_POPULATE;
      c.x0   = POS_BITS'(sx);
      c.y0   = POS_BITS'(sy);
      c.x1   = POS_BITS'(sx + 1);
      c.y1   = POS_BITS'(sy);
      repeat ((1 << COUNT_BITS) + 1) send_cmd(c, PREDICT, '0);
      c.func = FUNC_QUERY;
      send_cmd(c, PREDICT, '0);
      c.func = FUNC_DEPOPULATE;
      send_cmd(c, PREDICT, '0);
      c.func = FUNC_QUERY;
      send_cmd(c, PREDICT, '0);

      // random traffic around a moving hot spot
      cx = 0;
      cy = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(3))
               0:       cx = 2;
               1:       cx = GRID_WIDTH - 3;
               default: cx = $urandom_range(GRID_WIDTH - 1);
            endcase
            cy = $urandom_range(GRID_HEIGHT - 1);
         end
         if (n == 15) hold_armed = 1'b1;
         sender_quiet = (n >= 40 && n < 120);
         send_cmd(random_cmd(cx, cy), PREDICT, '0);
      end
      req_ch.valid <= 1'b0;

      // drain, then watch for stray responses
      while (answers.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (mismatches == 0 && answers.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
